// ===== rtl/blpd_pkg.sv =====
`default_nettype none

package blpd_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW = 5;
  localparam int unsigned TotalW = 5;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [1:0] {
    CMD_INSERT_FRONT = 2'd0,
    CMD_DELETE_FRONT = 2'd1,
    CMD_DELETE_END   = 2'd2,
    CMD_DELETE_POS   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SEL_HOLD  = 3'd0,
    SEL_LEFT  = 3'd1,
    SEL_RIGHT = 3'd2,
    SEL_HEAD  = 3'd3
  } cell_sel_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [CntW-1:0] count_t;

endpackage

`default_nettype wire

// ===== rtl/blpd_if.sv =====
`default_nettype none

interface blpd_cmd_if;
  logic                valid;
  logic                ready;
  blpd_pkg::cmd_e      cmd;
  blpd_pkg::word_t     value;
  logic [blpd_pkg::PosW-1:0] position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

interface blpd_res_if;
  logic                valid;
  logic                ready;
  blpd_pkg::status_e   status;
  logic [blpd_pkg::TotalW-1:0] entry_total;
  blpd_pkg::word_t     element;
  logic                last;

  modport source (output valid, output status, output entry_total, output element,
                  output last, input ready);
  modport sink (input valid, input status, input entry_total, input element,
                input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bounded_list_positional_delete_top.sv =====
// Channel  Dir  Payload                              Transfer
// cmd_i    in   cmd, value, position                 valid && ready
// res_o    out  status, entry_total, element, last   valid && ready
//
// A command updates the list as it is taken; the list is then read out, one result
// per cycle while res_o is ready, one result for each entry held after the update.
// An empty list yields one result.
// The results are read from the head cell while the occupied cells rotate one
// place per transfer, so a stall on res_o simply holds the rotation.
// A new command is taken only after the last result of the previous one.
// Reset empties the list; the cell contents themselves are not cleared.
`default_nettype none

module bounded_list_positional_delete_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  blpd_cmd_if.sink    cmd_i,
  blpd_res_if.source  res_o
);

  localparam int unsigned Depth = blpd_pkg::Depth;
  localparam int unsigned CntW = blpd_pkg::CntW;
  localparam int unsigned CmpW = blpd_pkg::CmpW;

  blpd_pkg::state_e    state_q, state_d;
  blpd_pkg::count_t    count_q, count_d;
  blpd_pkg::count_t    emit_q, emit_d;
  blpd_pkg::status_e   status_q, status_d;
  blpd_pkg::cell_sel_e sel [Depth];
  blpd_pkg::word_t     data [Depth];

  logic                in_xfer;
  logic                out_xfer;
  logic                last;
  logic [CmpW-1:0]     pos_ext;
  logic [CmpW-1:0]     count_ext;

  assign in_xfer   = cmd_i.valid && cmd_i.ready;
  assign out_xfer  = res_o.valid && res_o.ready;
  assign pos_ext   = CmpW'(cmd_i.position);
  assign count_ext = CmpW'(count_q);
  assign last      = (count_q == '0) || (emit_q + CntW'(1) == count_q);

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    blpd_pkg::word_t left;
    blpd_pkg::word_t right;

    if (i == 0) begin : g_first
      assign left = cmd_i.value;
    end else begin : g_mid
      assign left = data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right = data[i];
    end else begin : g_inner
      assign right = data[i+1];
    end

    blpd_cell u_cell (
      .clk_i  (clk_i),
      .sel_i  (sel[i]),
      .left_i (left),
      .right_i(right),
      .head_i (data[0]),
      .data_o (data[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      blpd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = blpd_pkg::ST_EMIT;
        end
      end
      blpd_pkg::ST_EMIT: begin
        if (out_xfer && last) begin
          state_d = blpd_pkg::ST_IDLE;
        end
      end
      default: state_d = blpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    emit_d   = emit_q;
    status_d = status_q;
    for (int i = 0; i < Depth; i++) begin
      sel[i] = blpd_pkg::SEL_HOLD;
    end

    case (state_q)
      blpd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          emit_d   = '0;
          status_d = blpd_pkg::STATUS_OK;
          case (cmd_i.cmd)
            blpd_pkg::CMD_INSERT_FRONT: begin
              if (count_q == CntW'(Depth)) begin
                status_d = blpd_pkg::STATUS_FULL;
              end else begin
                for (int i = 0; i < Depth; i++) begin
                  sel[i] = blpd_pkg::SEL_LEFT;
                end
                count_d = count_q + CntW'(1);
              end
            end
            blpd_pkg::CMD_DELETE_FRONT: begin
              if (count_q == '0) begin
                status_d = blpd_pkg::STATUS_EMPTY;
              end else begin
                for (int i = 0; i < Depth; i++) begin
                  if (CntW'(i) + CntW'(1) < count_q) begin
                    sel[i] = blpd_pkg::SEL_RIGHT;
                  end
                end
                count_d = count_q - CntW'(1);
              end
            end
            blpd_pkg::CMD_DELETE_END: begin
              if (count_q == '0) begin
                status_d = blpd_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            default: begin
              if (pos_ext == '0 || pos_ext > count_ext) begin
                status_d = blpd_pkg::STATUS_NOT_FOUND;
              end else begin
                for (int i = 0; i < Depth; i++) begin
                  if (CmpW'(i) + CmpW'(1) >= pos_ext &&
                      CntW'(i) + CntW'(1) < count_q) begin
                    sel[i] = blpd_pkg::SEL_RIGHT;
                  end
                end
                count_d = count_q - CntW'(1);
              end
            end
          endcase
          if (status_d == blpd_pkg::STATUS_OK && count_d == '0) begin
            status_d = blpd_pkg::STATUS_EMPTY;
          end
        end
      end
      blpd_pkg::ST_EMIT: begin
        if (out_xfer) begin
          emit_d = emit_q + CntW'(1);
          for (int i = 0; i < Depth; i++) begin
            if (CntW'(i) + CntW'(1) < count_q) begin
              sel[i] = blpd_pkg::SEL_RIGHT;
            end else if (CntW'(i) + CntW'(1) == count_q) begin
              sel[i] = blpd_pkg::SEL_HEAD;
            end
          end
        end
      end
      default: begin
        emit_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= blpd_pkg::ST_IDLE;
      count_q  <= '0;
      emit_q   <= '0;
      status_q <= blpd_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      emit_q   <= emit_d;
      status_q <= status_d;
    end
  end

  assign cmd_i.ready       = (state_q == blpd_pkg::ST_IDLE);
  assign res_o.valid       = (state_q == blpd_pkg::ST_EMIT);
  assign res_o.status      = status_q;
  assign res_o.entry_total = blpd_pkg::TotalW'(count_q);
  assign res_o.element     = (count_q == '0) ? '0 : data[0];
  assign res_o.last        = last;

endmodule

`default_nettype wire

// ===== rtl/blpd_cell.sv =====
`default_nettype none

module blpd_cell (
  input  wire                 clk_i,
  input  blpd_pkg::cell_sel_e sel_i,
  input  blpd_pkg::word_t     left_i,
  input  blpd_pkg::word_t     right_i,
  input  blpd_pkg::word_t     head_i,
  output blpd_pkg::word_t     data_o
);

  blpd_pkg::word_t data_q;
  blpd_pkg::word_t data_d;

  always_comb begin
    case (sel_i)
      blpd_pkg::SEL_LEFT:  data_d = left_i;
      blpd_pkg::SEL_RIGHT: data_d = right_i;
      blpd_pkg::SEL_HEAD:  data_d = head_i;
      default:             data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/blpd_checker.sv =====
`default_nettype none

module blpd_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_i,
  input wire                        out_valid_i,
  input wire                        out_ready_i,
  input wire [1:0]                  out_status_i,
  input wire [blpd_pkg::TotalW-1:0] out_entry_total_i,
  input wire [blpd_pkg::DataW-1:0]  out_element_i,
  input wire                        out_last_i
);

  // A command is followed by its results in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("results did not start after a command transfer");

  // No command is taken while results of the previous one are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("command ready while results are pending");

  // A result offered is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  // An empty list yields a single zero result that never reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_entry_total_i == '0 |->
      out_last_i && out_element_i == '0 && out_status_i != blpd_pkg::STATUS_OK)
    else $error("malformed result for an empty list");

endmodule

bind bounded_list_positional_delete_top blpd_checker u_blpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (cmd_i.valid),
  .in_ready_i       (cmd_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_status_i     (res_o.status),
  .out_entry_total_i(res_o.entry_total),
  .out_element_i    (res_o.element),
  .out_last_i       (res_o.last)
);

`default_nettype wire

// ===== test/bounded_list_positional_delete_top_tb.sv =====
module bounded_list_positional_delete_top_tb;

  localparam int unsigned Depth = blpd_pkg::Depth;
  localparam int unsigned PosW = blpd_pkg::PosW;
  localparam int unsigned TotalW = blpd_pkg::TotalW;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHoldAt = 400;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned RandomCommands = 210;
  localparam int unsigned SettleCycles = 40;

  typedef struct {
    blpd_pkg::cmd_e    op;
    blpd_pkg::word_t   value;
    logic [PosW-1:0]   position;
    int unsigned       gap;
    bit                drain;
  } list_command_t;

  typedef struct {
    blpd_pkg::status_e status;
    logic [TotalW-1:0] entry_total;
    blpd_pkg::word_t   element;
    logic              last;
  } list_result_t;

  logic clk;
  logic rst_n;

  blpd_cmd_if cmd_if ();
  blpd_res_if res_if ();

  bounded_list_positional_delete_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  list_command_t pending_cmd_q[$];
  list_result_t  expected_list_q[$];

  blpd_pkg::word_t shadow_list[Depth];
  int unsigned     shadow_count;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned results_seen;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          gen_quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("bounded_list_positional_delete_top_tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %0s", cycle_count, msg);
    error_count++;
  endtask

  // Applies one command to the shadow list and queues the full list dump it causes.
  task automatic apply_list_command(input blpd_pkg::cmd_e op, input blpd_pkg::word_t val,
                                    input logic [PosW-1:0] pos);
    blpd_pkg::status_e st;
    int unsigned       idx;
    list_result_t      r;
    st = blpd_pkg::STATUS_OK;
    case (op)
      blpd_pkg::CMD_INSERT_FRONT: begin
        if (shadow_count >= Depth) begin
          st = blpd_pkg::STATUS_FULL;
        end else begin
          for (idx = shadow_count; idx > 0; idx--) shadow_list[idx] = shadow_list[idx-1];
          shadow_list[0] = val;
          shadow_count++;
        end
      end
      blpd_pkg::CMD_DELETE_FRONT: begin
        if (shadow_count == 0) begin
          st = blpd_pkg::STATUS_EMPTY;
        end else begin
          for (idx = 0; idx + 1 < shadow_count; idx++) shadow_list[idx] = shadow_list[idx+1];
          shadow_count--;
        end
      end
      blpd_pkg::CMD_DELETE_END: begin
        if (shadow_count == 0) st = blpd_pkg::STATUS_EMPTY;
        else shadow_count--;
      end
      default: begin
        if (pos < 1 || pos > shadow_count) begin
          st = blpd_pkg::STATUS_NOT_FOUND;
        end else begin
          for (idx = pos - 1; idx + 1 < shadow_count; idx++) begin
            shadow_list[idx] = shadow_list[idx+1];
          end
          shadow_count--;
        end
      end
    endcase
    if (st == blpd_pkg::STATUS_OK && shadow_count == 0) st = blpd_pkg::STATUS_EMPTY;
    if (shadow_count == 0) begin
      r.status = st;
      r.entry_total = '0;
      r.element = '0;
      r.last = 1'b1;
      expected_list_q.push_back(r);
    end else begin
      for (idx = 0; idx < shadow_count; idx++) begin
        r.status = st;
        r.entry_total = TotalW'(shadow_count);
        r.element = shadow_list[idx];
        r.last = (idx + 1 == shadow_count);
        expected_list_q.push_back(r);
      end
    end
  endtask

  task automatic queue_command(input blpd_pkg::cmd_e op, input blpd_pkg::word_t val,
                               input logic [PosW-1:0] pos, input bit drain);
    list_command_t c;
    c.op = op;
    c.value = val;
    c.position = pos;
    c.gap = gen_quiet ? 0 : $urandom_range(0, 3);
    c.drain = drain;
    pending_cmd_q.push_back(c);
  endtask

  always @(posedge clk or negedge rst_n) begin
    list_command_t c;
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
      cmd_if.cmd <= blpd_pkg::CMD_INSERT_FRONT;
      cmd_if.value <= '0;
      cmd_if.position <= '0;
      gap_left <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_list_command(cmd_if.cmd, cmd_if.value, cmd_if.position);
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          cmd_if.valid <= 1'b0;
        end else if (pending_cmd_q.size() > 0 &&
                     !(pending_cmd_q[0].drain && expected_list_q.size() > 0)) begin
          c = pending_cmd_q.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.cmd <= c.op;
          cmd_if.value <= c.value;
          cmd_if.position <= c.position;
          gap_left <= c.gap;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    list_result_t want;
    int unsigned  n;
    if (!rst_n) begin
      res_if.ready <= 1'b1;
      stall_left <= 0;
      results_seen <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if (expected_list_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, element %0d", res_if.element));
      end else begin
        want = expected_list_q.pop_front();
        if (res_if.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", res_if.status, want.status));
        end
        if (res_if.entry_total !== want.entry_total) begin
          report_mismatch($sformatf("entry_total %0d, expected %0d",
                                    res_if.entry_total, want.entry_total));
        end
        if (res_if.element !== want.element) begin
          report_mismatch($sformatf("element %0d, expected %0d",
                                    res_if.element, want.element));
        end
        if (res_if.last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", res_if.last, want.last));
        end
      end
      results_seen <= results_seen + 1;
      if (results_seen + 1 == LongHoldAt) begin
        n = LongHoldCycles;
      end else if ((results_seen / 64) % 4 == 3) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 3);
      end
      res_if.ready <= (n == 0);
      stall_left <= n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end
  end

  initial begin
    int unsigned     ins_pct;
    blpd_pkg::cmd_e  op;
    blpd_pkg::word_t val;
    logic [PosW-1:0] pos;
    rst_n <= 1'b0;
    error_count = 0;
    shadow_count = 0;
    gen_quiet = 1'b0;
    ins_pct = 50;

    queue_command(blpd_pkg::CMD_DELETE_FRONT, '0, '0, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_END, '0, '0, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_POS, '0, 5'd1, 1'b0);
    queue_command(blpd_pkg::CMD_INSERT_FRONT, 32'sh8000_0000, '0, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_POS, '0, 5'd1, 1'b0);
    queue_command(blpd_pkg::CMD_INSERT_FRONT, 32'sh7FFF_FFFF, '0, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_END, '0, '0, 1'b0);
    queue_command(blpd_pkg::CMD_INSERT_FRONT, '0, '0, 1'b0);
    queue_command(blpd_pkg::CMD_INSERT_FRONT, -32'sd1, '0, 1'b0);
    queue_command(blpd_pkg::CMD_INSERT_FRONT, 32'sh8000_0000, '0, 1'b0);
    queue_command(blpd_pkg::CMD_INSERT_FRONT, 32'sh7FFF_FFFF, '0, 1'b0);
    for (int i = 0; i < 12; i++) begin
      queue_command(blpd_pkg::CMD_INSERT_FRONT, blpd_pkg::word_t'($urandom), '0, 1'b0);
    end
    queue_command(blpd_pkg::CMD_INSERT_FRONT, 32'sh1234_5678, '0, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_POS, '0, 5'd16, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_POS, '0, 5'd0, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_POS, '0, 5'd31, 1'b0);
    queue_command(blpd_pkg::CMD_DELETE_FRONT, '0, '0, 1'b0);

    for (int i = 0; i < RandomCommands; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 25;
          1: ins_pct = 55;
          default: ins_pct = 85;
        endcase
        gen_quiet = ((i / 30) % 3 == 2);
      end
      if ($urandom_range(0, 99) < ins_pct) op = blpd_pkg::CMD_INSERT_FRONT;
      else op = blpd_pkg::cmd_e'($urandom_range(1, 3));
      case ($urandom_range(0, 7))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7FFF_FFFF;
        default: val = blpd_pkg::word_t'($urandom);
      endcase
      if ($urandom_range(0, 3) != 0) pos = PosW'($urandom_range(1, Depth));
      else pos = PosW'($urandom_range(0, 31));
      queue_command(op, val, pos, (i == 0 || i == 100));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_cmd_q.size() != 0 || cmd_if.valid || expected_list_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("bounded_list_positional_delete_top_tb: clean");
    end else begin
      $display("bounded_list_positional_delete_top_tb: errors");
    end
    $finish;
  end

endmodule
